// File: design/rnct_pkg.sv
// Shared types and constants for the raster neighbour count threshold unit.
`timescale 1ns / 1ps

package rnct_pkg;

  typedef logic [7:0]  symbol_t;
  typedef logic [7:0]  col8_t;
  typedef logic [8:0]  row_width_t;
  typedef logic [3:0]  limit_t;
  typedef logic [19:0] total_t;
  typedef logic [8:0]  window_t;
  typedef logic [1:0]  rows_t;
  typedef logic [1:0]  lb_word_t;
  typedef logic [1:0]  cfg_index_t;
  typedef logic [8:0]  cfg_data_t;

  localparam symbol_t    OCCUPIED_SYMBOL = 8'h40;
  localparam total_t     TOTAL_MAX       = 20'hFFFFF;
  localparam row_width_t ROW_WIDTH_RESET = 9'd256;
  localparam limit_t     LIMIT_RESET     = 4'd4;
  localparam rows_t      ROWS_FULL       = 2'd2;
  localparam int         LB_W            = 2;

  localparam cfg_index_t REG_ROW_WIDTH       = 2'd0;
  localparam cfg_index_t REG_NEIGHBOUR_LIMIT = 2'd1;

  // One cell leaving the window stage: the updated 3x3 window and which
  // of its two possible decisions are due.
  typedef struct packed {
    logic    first;
    logic    second;
    logic    sof;
    col8_t   col;
    window_t win;
  } job_t;

endpackage

// File: design/rnct_in_if.sv
// Input request channel: one grid cell per request.
`timescale 1ns / 1ps

interface rnct_in_if import rnct_pkg::*; ();
  logic    valid;
  logic    ready;
  symbol_t symbol;
  logic    start_of_frame;

  modport source (output valid, output symbol, output start_of_frame, input ready);
  modport sink (input valid, input symbol, input start_of_frame, output ready);
endinterface

// File: design/rnct_out_if.sv
// Result request channel: one decided cell per request.
`timescale 1ns / 1ps

interface rnct_out_if import rnct_pkg::*; ();
  logic   valid;
  logic   ready;
  col8_t  cell_column;
  logic   accessible;
  total_t running_total;
  logic   last_of_run;

  modport source (output valid, output cell_column, output accessible,
                  output running_total, output last_of_run, input ready);
  modport sink (input valid, input cell_column, input accessible,
                input running_total, input last_of_run, output ready);
endinterface

// File: design/rnct_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface rnct_cfg_if import rnct_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/rnct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rnct_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/rnct_window.sv
// Column and row tracking, line buffers and the 3x3 window update.
`timescale 1ns / 1ps

module rnct_window import rnct_pkg::*; #(
  parameter int MAX_WIDTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  row_width_t    row_width_i,
  rnct_in_if.sink       in_req,
  output job_t          job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

  logic [AW-1:0] col_r;
  rows_t         rows_r;

  logic          s1_valid_r;
  logic          s1_occ_r;
  logic [AW-1:0] s1_col_r;
  logic          s1_last_r;
  rows_t         s1_rows_r;
  logic          s1_sof_r;
  logic          fwd_r;
  lb_word_t      fwd_data_r;
  window_t       win_r;

  logic          accept;
  logic          advance;
  logic [AW-1:0] eff_col;
  rows_t         eff_rows;
  logic [CW-1:0] rw_ext;
  logic [CW-1:0] w_eff;
  logic [CW-1:0] c_ext;
  logic          last;
  logic          occ;
  lb_word_t      rd_data;
  lb_word_t      lb;
  lb_word_t      wr_data;
  logic          top;
  logic          mid;
  logic [2:0]    col_bits;
  window_t       win_nxt;
  logic [CW-1:0] s1_col_ext;

  assign in_req.ready = !s1_valid_r || job_ready_i;
  assign accept       = in_req.valid && in_req.ready;
  assign advance      = s1_valid_r && job_ready_i;

  // Accept side: where the new cell sits in the grid.
  always_comb begin
    eff_col  = in_req.start_of_frame ? '0 : col_r;
    eff_rows = in_req.start_of_frame ? '0 : rows_r;
    rw_ext   = CW'(row_width_i);
    if (rw_ext == '0) begin
      w_eff = CW'(1);
    end else if (rw_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = rw_ext;
    end
    c_ext = CW'(eff_col);
    last  = (c_ext + CW'(1)) >= w_eff;
    occ   = (in_req.symbol == OCCUPIED_SYMBOL);
  end

  rnct_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (s1_col_r),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (eff_col),
    .rd_data (rd_data)
  );

  // Stage 1: line buffer column arrives, window shifts in the new column.
  always_comb begin
    lb         = fwd_r ? fwd_data_r : rd_data;
    top        = s1_rows_r[1] ? lb[1] : 1'b0;
    mid        = (s1_rows_r != '0) ? lb[0] : 1'b0;
    col_bits   = {s1_occ_r, mid, top};
    wr_data    = {mid, s1_occ_r};
    win_nxt    = ((s1_col_r == '0) ? '0 : {3'b000, win_r[8:3]}) | {col_bits, 6'b000000};
    s1_col_ext = CW'(s1_col_r);

    job_o.first  = (s1_rows_r != '0) && (s1_col_r != '0);
    job_o.second = (s1_rows_r != '0) && s1_last_r;
    job_o.sof    = s1_sof_r;
    job_o.col    = s1_col_ext[7:0];
    job_o.win    = win_nxt;
  end

  assign job_valid_o = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      rows_r     <= '0;
      s1_valid_r <= 1'b0;
      win_r      <= '0;
      fwd_r      <= 1'b0;
    end else begin
      if (accept) begin
        col_r      <= last ? '0 : eff_col + AW'(1);
        rows_r     <= (last && eff_rows != ROWS_FULL) ? eff_rows + rows_t'(1) : eff_rows;
        s1_valid_r <= 1'b1;
        fwd_r      <= advance && (s1_col_r == eff_col);
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_occ_r   <= occ;
      s1_col_r   <= eff_col;
      s1_last_r  <= last;
      s1_rows_r  <= eff_rows;
      s1_sof_r   <= in_req.start_of_frame;
      fwd_data_r <= wr_data;
    end
  end

endmodule

// File: design/rnct_decide.sv
// Neighbour count, threshold decision, running total and result register.
`timescale 1ns / 1ps

module rnct_decide import rnct_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  limit_t limit_i,
  input  job_t   job_i,
  input  logic   job_valid_i,
  output logic   job_ready_o,
  rnct_out_if.source out_req
);

  logic    j_valid_r;
  logic    j_first_r;
  logic    j_second_r;
  col8_t   j_col_r;
  window_t j_win_r;

  logic    o_valid_r;
  col8_t   o_col_r;
  logic    o_acc_r;
  total_t  o_total_r;
  logic    o_last_r;
  total_t  total_r;

  logic    o_load;
  logic    emit;
  logic    j_done;
  logic    take;
  window_t w;
  col8_t   col;
  logic    run_last;
  logic [3:0] nb;
  logic    acc;
  total_t  total_inc;

  assign o_load      = !o_valid_r || out_req.ready;
  assign emit        = j_valid_r && o_load;
  assign j_done      = emit && !(j_first_r && j_second_r);
  assign job_ready_o = !j_valid_r || j_done;
  assign take        = job_valid_i && job_ready_o;

  always_comb begin
    // The first decision is the cell left of the newest column; the
    // second, at row end, is the newest column itself.
    w        = j_first_r ? j_win_r : {3'b000, j_win_r[8:3]};
    col      = j_first_r ? j_col_r - 8'd1 : j_col_r;
    run_last = !(j_first_r && j_second_r);
    nb       = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        nb = nb + 4'(w[i]);
      end
    end
    acc       = w[4] && (nb < limit_i);
    total_inc = (acc && total_r != TOTAL_MAX) ? total_r + total_t'(1) : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_valid_r  <= 1'b0;
      j_first_r  <= 1'b0;
      j_second_r <= 1'b0;
      o_valid_r  <= 1'b0;
      total_r    <= '0;
    end else begin
      if (take) begin
        j_valid_r  <= job_i.first || job_i.second;
        j_first_r  <= job_i.first;
        j_second_r <= job_i.second;
      end else if (emit) begin
        if (j_first_r) begin
          j_first_r <= 1'b0;
          j_valid_r <= j_second_r;
        end else begin
          j_second_r <= 1'b0;
          j_valid_r  <= 1'b0;
        end
      end
      if (o_load) begin
        o_valid_r <= emit;
      end
      if (take && job_i.sof) begin
        total_r <= '0;
      end else if (emit) begin
        total_r <= total_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      j_col_r <= job_i.col;
      j_win_r <= job_i.win;
    end
    if (emit) begin
      o_col_r   <= col;
      o_acc_r   <= acc;
      o_total_r <= total_inc;
      o_last_r  <= run_last;
    end
  end

  assign out_req.valid         = o_valid_r;
  assign out_req.cell_column   = o_col_r;
  assign out_req.accessible    = o_acc_r;
  assign out_req.running_total = o_total_r;
  assign out_req.last_of_run   = o_last_r;

endmodule

// File: design/raster_neighbour_count_threshold_unit.sv
// Top level of the raster neighbour count threshold unit.
`timescale 1ns / 1ps

// The block takes a binary grid in raster order on in_req, one cell per
// request, and flags each occupied cell ('@') whose count of occupied
// 8-neighbours is below the neighbour limit, with a saturating total.
// A cell is decided while the row below it streams in, so the host sends
// one empty row after the last row. start_of_frame on the first cell of a
// grid clears the total and the row count.
// Results leave on out_req: a cell at column one or more decides the cell
// to its left in the row above, and the last cell of a row also decides
// its own column of the row above, so one request gives zero, one or two
// results; last_of_run marks the final one.
// An accepted request passes the window and decision stage registers before
// its first result reaches the output register. One request is taken every
// cycle unless stalled; a row-end request with two results holds the input
// back, as the decision stage emits one result a cycle. When the receiver
// stalls, the result register holds, the window and decision stages fill
// behind it and in_req.ready then drops in the same cycle. cfg_req writes
// row_width (index 0) and neighbour_limit (index 1) and is always ready;
// the host must write it only while the block is idle, as the block does
// not enforce this. Reset restores the register defaults and empties the
// pipeline; the line buffer RAM is not cleared and needs no clearing pass.
module raster_neighbour_count_threshold_unit import rnct_pkg::*; #(
  parameter int MAX_WIDTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  rnct_in_if.sink     in_req,
  rnct_out_if.source  out_req,
  rnct_cfg_if.sink    cfg_req
);

  row_width_t row_width_r;
  limit_t     limit_r;

  job_t job;
  logic job_valid;
  logic job_ready;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
      limit_r     <= LIMIT_RESET;
    end else if (cfg_req.valid) begin
      case (cfg_req.index)
        REG_ROW_WIDTH: begin
          row_width_r <= cfg_req.data;
        end
        REG_NEIGHBOUR_LIMIT: begin
          limit_r <= cfg_req.data[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Window stage: tracks the raster position and builds the 3x3 window
  // from the line buffers and the incoming cell.
  rnct_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .row_width_i (row_width_r),
    .in_req      (in_req),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  // Decision stage: counts neighbours, keeps the total and drives the
  // result register, one result per cycle while the receiver is ready.
  rnct_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .limit_i     (limit_r),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .out_req     (out_req)
  );

`ifndef SYNTHESIS
  // The second result of a row-end cell follows the first right away.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_req.valid && out_req.ready && !out_req.last_of_run) |=> out_req.valid)
    else $error("second result of a row-end cell did not follow");

  // An accessible cell is already included in the total it reports.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_req.valid && out_req.accessible) |-> (out_req.running_total != '0))
    else $error("accessible result with a zero total");

  // Once the decision stage takes a job with a decision in it, the job passes
  // its decision register into the result register or finds it still busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_ready && (job.first || job.second)) |-> ##2 out_req.valid)
    else $error("decision job did not produce a result");
`endif

endmodule
